### hdl/ltsc_pkg.sv
// Shared constants, operation codes and stack command type for the tile slot cache.
`timescale 1ns / 1ps
`default_nettype none

package ltsc_pkg;

	localparam int SLOTS_DEF          = 256;
	localparam int RESIDENT_LIMIT_DEF = 256;
	localparam int KEY_BITS_DEF       = 32;
	localparam int STAMP_BITS         = 64;
	localparam int TILE_KEY_BITS      = 32;
	localparam int SLOT_OUT_BITS      = 8;
	localparam int OP_BITS            = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_ALLOCATE = 2'd0,
		OP_TOUCH    = 2'd1,
		OP_LOOKUP   = 2'd2,
		OP_RESERVED = 2'd3
	} op_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

endpackage

`default_nettype wire

### hdl/lru_tile_slot_cache_top.sv
// Top level of the tile slot cache: request sequencer, entry RAM scan and output register.
// Usage:
//   Input channel (in_valid/in_ready) carries operation and tile_key; the output channel
//   (out_valid/out_ready) returns slot_index and found, exactly one transaction per request.
//   Requests are handled one at a time. Each request scans the entry RAM once (evicting
//   allocates may scan again), one entry per cycle through its single read port; a hit or
//   lookup then passes a decide step to the output step, and an allocate that pops a free
//   slot also passes a pop and a write step.
//   An allocate that finds the free stack empty evicts the oldest entry found in the same
//   scan; each further eviction needed to reach the resident limit costs one more scan
//   (SLOTS - min(RESIDENT_LIMIT, SLOTS) extra scans).
//   in_ready is high whenever no request is in progress; a finished result sits in the
//   output register, so a new request is taken while the receiver stalls, and the next
//   result waits in the sequencer until the output register is free.
//   After reset no entry is resident, the access counter is zero and slots are handed
//   out in order from slot 0. No clearing pass is needed: the block is ready right away.
//   Keys are compared on their low KEY_BITS bits; slot_index is the slot modulo 256.
`timescale 1ns / 1ps
`default_nettype none

module lru_tile_slot_cache_top
	import ltsc_pkg::*;
#(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int RESIDENT_LIMIT = RESIDENT_LIMIT_DEF,
	parameter int KEY_BITS       = KEY_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [OP_BITS-1:0]       operation,
	input  wire logic [TILE_KEY_BITS-1:0] tile_key,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic      [SLOT_OUT_BITS-1:0] slot_index,
	output logic                          found
);

	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int CNT_BITS  = $clog2(SLOTS + 1);
	localparam int LIM       = (RESIDENT_LIMIT < SLOTS) ? RESIDENT_LIMIT : SLOTS;
	localparam int REFILL    = SLOTS - LIM;
	localparam int ENTRY_W   = 1 + KEY_BITS + STAMP_BITS;
	localparam int WIDE_BITS = (SLOT_BITS > SLOT_OUT_BITS) ? SLOT_BITS : SLOT_OUT_BITS;

	typedef enum logic [7:0] {
		S_IDLE       = 8'b0000_0001,
		S_SCAN       = 8'b0000_0010,
		S_DECIDE     = 8'b0000_0100,
		S_EVICT_WR   = 8'b0000_1000,
		S_EVICT_SCAN = 8'b0001_0000,
		S_POP        = 8'b0010_0000,
		S_WRITE      = 8'b0100_0000,
		S_OUT        = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [STAMP_BITS-1:0]   counter_q;
	logic [STAMP_BITS-1:0]   counter_inc;
	logic [SLOT_BITS-1:0]    scan_addr_q;
	logic                    issue_done_q;
	logic                    rd_vld_s1;
	logic [SLOT_BITS-1:0]    rd_addr_s1;
	logic                    hit_q;
	logic [SLOT_BITS-1:0]    hit_slot_q;
	logic                    min_found_q;
	logic [SLOT_BITS-1:0]    min_slot_q;
	logic [STAMP_BITS-1:0]   min_stamp_q;
	logic [SLOT_BITS-1:0]    res_slot_q;
	logic                    res_found_q;
	logic                    out_valid_q;
	logic [SLOT_OUT_BITS-1:0] slot_index_q;
	logic                    found_q;

	logic                    scanning;
	logic                    rd_en;
	logic                    last_s1;
	logic [ENTRY_W-1:0]      rd_data;
	logic                    ent_valid;
	logic [KEY_BITS-1:0]     ent_key;
	logic [STAMP_BITS-1:0]   ent_stamp;
	logic                    ent_live;
	logic                    we;
	logic [SLOT_BITS-1:0]    waddr;
	logic [ENTRY_W-1:0]      wdata;
	logic [63:0]             key_wide;
	logic [WIDE_BITS-1:0]    res_wide;
	logic                    accept;
	logic                    out_load;

	stack_cmd_t              stk_cmd;
	logic [CNT_BITS-1:0]     free_cnt;
	logic                    wrapped;
	logic [SLOT_BITS-1:0]    pop_slot;
	logic [CNT_BITS-1:0]     alloc_cnt;

	assign accept      = in_valid && in_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign counter_inc = counter_q + 1'b1;
	assign key_wide    = {32'b0, tile_key};
	assign scanning    = (state_q == S_SCAN) || (state_q == S_EVICT_SCAN);
	assign rd_en       = scanning && !issue_done_q;
	assign last_s1     = rd_vld_s1 && (rd_addr_s1 == SLOT_BITS'(SLOTS - 1));
	assign alloc_cnt   = CNT_BITS'(SLOTS) - free_cnt;

	assign ent_valid = rd_data[ENTRY_W-1];
	assign ent_key   = rd_data[STAMP_BITS +: KEY_BITS];
	assign ent_stamp = rd_data[STAMP_BITS-1:0];
	assign ent_live  = ent_valid && (wrapped || (CNT_BITS'(rd_addr_s1) < alloc_cnt));

	ltsc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(scan_addr_q),
		.rdata(rd_data)
	);

	ltsc_free_stack #(
		.SLOTS(SLOTS)
	) u_free_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (stk_cmd),
		.push_slot(min_slot_q),
		.count    (free_cnt),
		.wrapped  (wrapped),
		.pop_slot (pop_slot)
	);

	always_comb begin
		we           = 1'b0;
		waddr        = hit_slot_q;
		wdata        = {1'b1, key_q, counter_inc};
		stk_cmd.push = 1'b0;
		stk_cmd.pop  = 1'b0;
		unique case (state_q)
			S_DECIDE: begin
				we = hit_q && ((op_q == OP_ALLOCATE) || (op_q == OP_TOUCH));
			end
			S_EVICT_WR: begin
				we           = 1'b1;
				waddr        = min_slot_q;
				wdata        = {1'b0, key_q, counter_q};
				stk_cmd.push = 1'b1;
			end
			S_POP: begin
				stk_cmd.pop = 1'b1;
			end
			S_WRITE: begin
				we    = 1'b1;
				waddr = pop_slot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			counter_q    <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				if (scan_addr_q == SLOT_BITS'(SLOTS - 1)) begin
					issue_done_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						issue_done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (last_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (hit_q) begin
						if ((op_q == OP_ALLOCATE) || (op_q == OP_TOUCH)) begin
							counter_q <= counter_inc;
						end
						state_q <= S_OUT;
					end else if (op_q == OP_ALLOCATE) begin
						state_q <= (free_cnt == '0) ? S_EVICT_WR : S_POP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_EVICT_WR: begin
					if (free_cnt < CNT_BITS'(REFILL)) begin
						state_q      <= S_EVICT_SCAN;
						issue_done_q <= 1'b0;
					end else begin
						state_q <= S_POP;
					end
				end
				S_EVICT_SCAN: begin
					if (last_s1) begin
						state_q <= S_EVICT_WR;
					end
				end
				S_POP: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					counter_q <= counter_inc;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_t'(operation);
			key_q       <= key_wide[KEY_BITS-1:0];
			scan_addr_q <= '0;
			hit_q       <= 1'b0;
			min_found_q <= 1'b0;
		end else if (state_q == S_EVICT_WR) begin
			scan_addr_q <= '0;
			min_found_q <= 1'b0;
		end else if (rd_en && !(scan_addr_q == SLOT_BITS'(SLOTS - 1))) begin
			scan_addr_q <= scan_addr_q + 1'b1;
		end
		if (rd_vld_s1) begin
			if (ent_live && (ent_key == key_q) && !hit_q) begin
				hit_q      <= 1'b1;
				hit_slot_q <= rd_addr_s1;
			end
			if (ent_live && (!min_found_q || (ent_stamp < min_stamp_q))) begin
				min_found_q <= 1'b1;
				min_slot_q  <= rd_addr_s1;
				min_stamp_q <= ent_stamp;
			end
		end
		rd_addr_s1 <= scan_addr_q;
		if (state_q == S_DECIDE) begin
			res_slot_q  <= hit_q ? hit_slot_q : '0;
			res_found_q <= hit_q;
		end else if (state_q == S_WRITE) begin
			res_slot_q  <= pop_slot;
			res_found_q <= 1'b0;
		end
		if (out_load) begin
			slot_index_q <= res_wide[SLOT_OUT_BITS-1:0];
			found_q      <= res_found_q;
		end
	end

	assign res_wide   = WIDE_BITS'(res_slot_q);
	assign out_valid  = out_valid_q;
	assign slot_index = slot_index_q;
	assign found      = found_q;

endmodule

`default_nettype wire

### hdl/ltsc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ltsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/ltsc_free_stack.sv
// LIFO stack of free slot numbers, held in a RAM, with its fill count.
`timescale 1ns / 1ps
`default_nettype none

module ltsc_free_stack
	import ltsc_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SLOT_BITS = $clog2(SLOTS),
	localparam int CNT_BITS  = $clog2(SLOTS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stack_cmd_t           cmd,
	input  wire logic [SLOT_BITS-1:0] push_slot,
	output logic      [CNT_BITS-1:0]  count,
	output logic                      wrapped,
	output logic      [SLOT_BITS-1:0] pop_slot
);

	logic [CNT_BITS-1:0]  count_q;
	logic                 wrapped_q;
	logic [CNT_BITS-1:0]  pop_idx;
	logic [CNT_BITS-1:0]  calc_full;
	logic [SLOT_BITS-1:0] calc_q;
	logic                 from_ram_q;
	logic [SLOT_BITS-1:0] ram_rdata;

	assign pop_idx   = count_q - 1'b1;
	assign calc_full = CNT_BITS'(SLOTS) - count_q;

	ltsc_ram #(
		.WIDTH(SLOT_BITS),
		.DEPTH(SLOTS)
	) u_stack_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(count_q[SLOT_BITS-1:0]),
		.wdata(push_slot),
		.re   (cmd.pop),
		.raddr(pop_idx[SLOT_BITS-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CNT_BITS'(SLOTS);
			wrapped_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q   <= count_q + 1'b1;
				wrapped_q <= 1'b1;
			end else if (cmd.pop) begin
				count_q <= pop_idx;
			end
		end
	end

	// hold the reset ordering until the first slot is pushed back
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			calc_q     <= calc_full[SLOT_BITS-1:0];
			from_ram_q <= wrapped_q;
		end
	end

	assign count    = count_q;
	assign wrapped  = wrapped_q;
	assign pop_slot = from_ram_q ? ram_rdata : calc_q;

endmodule

`default_nettype wire

### test/lru_tile_slot_cache_top_test.sv
// Self-checking testbench for the tile slot cache: random handshakes, LRU slot prediction.
`timescale 1ns / 1ps

module lru_tile_slot_cache_top_test
	import ltsc_pkg::*;
();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 2 * SLOTS_DEF + 50;
	localparam int CALM_TAIL = 100;
	localparam int FILL_ITEMS = 250;
	localparam int CHURN_ITEMS = 440;
	localparam int KEEP_LIMIT = (RESIDENT_LIMIT_DEF < SLOTS_DEF ? RESIDENT_LIMIT_DEF : SLOTS_DEF) - 1;
	localparam logic [TILE_KEY_BITS-1:0] KEY_MASK =
		(KEY_BITS_DEF >= TILE_KEY_BITS) ? '1 : (32'd1 << KEY_BITS_DEF) - 32'd1;

	typedef struct {
		op_t                      op;
		logic [TILE_KEY_BITS-1:0] key;
	} tile_request_t;

	typedef struct {
		logic [SLOT_OUT_BITS-1:0] slot;
		logic                     hit;
	} slot_reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_BITS-1:0]       operation = OP_ALLOCATE;
	logic [TILE_KEY_BITS-1:0] tile_key = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SLOT_OUT_BITS-1:0] slot_index;
	logic                     found;

	logic in_took = 1'b0;
	int   send_gap = 0;
	int   recv_stall = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	tile_request_t            request_queue[$];
	slot_reply_t              slot_replies[$];
	logic [TILE_KEY_BITS-1:0] key_pool[$];

	logic                     entry_valid[SLOTS_DEF];
	logic [TILE_KEY_BITS-1:0] entry_key[SLOTS_DEF];
	logic [STAMP_BITS-1:0]    entry_stamp[SLOTS_DEF];
	logic [STAMP_BITS-1:0]    stamp_clock;
	int                       free_slots[SLOTS_DEF];
	int                       free_depth;
	int                       resident_total;

	lru_tile_slot_cache_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.tile_key   (tile_key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.found      (found)
	);

	always #5 clk = ~clk;

	task automatic apply_request(input op_t op, input logic [TILE_KEY_BITS-1:0] raw_key);
		logic [TILE_KEY_BITS-1:0] key;
		int                       hit_slot;
		int                       oldest;
		int                       slot;
		slot_reply_t              reply;
		key = raw_key & KEY_MASK;
		hit_slot = -1;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (hit_slot < 0 && entry_valid[i] && entry_key[i] == key)
				hit_slot = i;
		end
		reply.slot = '0;
		reply.hit = 1'b0;
		if (hit_slot >= 0) begin
			reply.slot = hit_slot[SLOT_OUT_BITS-1:0];
			reply.hit = 1'b1;
			if (op == OP_ALLOCATE || op == OP_TOUCH) begin
				stamp_clock++;
				entry_stamp[hit_slot] = stamp_clock;
			end
		end else if (op == OP_ALLOCATE) begin
			if (free_depth == 0) begin
				while (resident_total > KEEP_LIMIT) begin
					oldest = -1;
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (entry_valid[i] && (oldest < 0 || entry_stamp[i] < entry_stamp[oldest]))
							oldest = i;
					end
					entry_valid[oldest] = 1'b0;
					resident_total--;
					if (free_depth < SLOTS_DEF) begin
						free_slots[free_depth] = oldest;
						free_depth++;
					end
				end
			end
			if (free_depth > 0) begin
				free_depth--;
				slot = free_slots[free_depth] % SLOTS_DEF;
				stamp_clock++;
				entry_valid[slot] = 1'b1;
				entry_key[slot] = key;
				entry_stamp[slot] = stamp_clock;
				resident_total++;
				reply.slot = slot[SLOT_OUT_BITS-1:0];
			end
		end
		slot_replies.insert(slot_replies.size(), reply);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0d: %s expected %0h actual %0h", mismatch_count, what, want, got);
	endtask

	task automatic queue_request(input op_t op, input logic [TILE_KEY_BITS-1:0] key);
		tile_request_t req;
		req.op = op;
		req.key = key;
		request_queue.insert(request_queue.size(), req);
	endtask

	task automatic pool_key(input logic [TILE_KEY_BITS-1:0] key);
		key_pool.insert(key_pool.size(), key);
	endtask

	function automatic op_t random_op();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return OP_ALLOCATE;
		else if (r < 7)
			return OP_TOUCH;
		else if (r < 9)
			return OP_LOOKUP;
		return OP_RESERVED;
	endfunction

	always @(posedge clk) begin
		slot_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (slot_replies.size() == 0) begin
					report_mismatch("unexpected transaction slot", '0, slot_index);
				end else begin
					want = slot_replies.pop_front();
					if (slot_index !== want.slot)
						report_mismatch("slot_index", want.slot, slot_index);
					if (found !== want.hit)
						report_mismatch("found", want.hit, found);
				end
			end
			if (in_valid && in_ready)
				apply_request(op_t'(operation), tile_key);
		end
		in_took <= arst_n && in_valid && in_ready;
	end

	always @(negedge clk) begin
		tile_request_t next_req;
		logic          next_valid;
		logic          calm;
		if (arst_n) begin
			calm = request_queue.size() < CALM_TAIL;
			next_valid = in_valid;
			if (!in_valid || in_took) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 15);
				end else if (request_queue.size() > 0) begin
					next_req = request_queue.pop_front();
					operation <= next_req.op;
					tile_key <= next_req.key;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				recv_stall = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [TILE_KEY_BITS-1:0] key;
		op_t                      op;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			entry_valid[i] = 1'b0;
			entry_key[i] = '0;
			entry_stamp[i] = '0;
			free_slots[i] = SLOTS_DEF - 1 - i;
		end
		stamp_clock = '0;
		free_depth = SLOTS_DEF;
		resident_total = 0;

		queue_request(OP_LOOKUP, 32'h0000_0000);
		queue_request(OP_TOUCH, 32'h0000_0000);
		queue_request(OP_ALLOCATE, 32'h0000_0000);
		queue_request(OP_ALLOCATE, 32'hFFFF_FFFF);
		queue_request(OP_ALLOCATE, 32'h0000_0000);
		queue_request(OP_TOUCH, 32'hFFFF_FFFF);
		queue_request(OP_LOOKUP, 32'h0000_0000);
		queue_request(OP_RESERVED, 32'hFFFF_FFFF);
		queue_request(OP_RESERVED, 32'h1234_5678);
		queue_request(OP_LOOKUP, 32'h1234_5678);
		queue_request(OP_ALLOCATE, 32'h8000_0000);
		queue_request(OP_ALLOCATE, 32'h7FFF_FFFF);
		queue_request(OP_ALLOCATE, 32'hAAAA_AAAA);
		queue_request(OP_ALLOCATE, 32'h5555_5555);
		queue_request(OP_TOUCH, 32'h5555_5555);
		queue_request(OP_LOOKUP, 32'hAAAA_AAAA);
		pool_key(32'h0000_0000);
		pool_key(32'hFFFF_FFFF);
		pool_key(32'h8000_0000);
		pool_key(32'h7FFF_FFFF);
		pool_key(32'hAAAA_AAAA);
		pool_key(32'h5555_5555);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() > 0 || in_valid || slot_replies.size() > 0)
			@(posedge clk);

		for (int i = 0; i < FILL_ITEMS; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				key = $urandom;
				pool_key(key);
				queue_request(OP_ALLOCATE, key);
			end else begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				queue_request($urandom_range(0, 1) ? OP_TOUCH : OP_LOOKUP, key);
			end
		end
		for (int i = 0; i < CHURN_ITEMS; i++) begin
			op = random_op();
			if ($urandom_range(0, 99) < 85) begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end else begin
				key = $urandom;
				if (op == OP_ALLOCATE)
					pool_key(key);
			end
			queue_request(op, key);
		end

		while (request_queue.size() > 0 || in_valid || slot_replies.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && slot_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
hdl/ltsc_pkg.sv
hdl/ltsc_ram.sv
hdl/ltsc_free_stack.sv
hdl/lru_tile_slot_cache_top.sv
test/lru_tile_slot_cache_top_test.sv
